// File: src/tos_pkg.sv
`default_nettype none

package tos_pkg;

    localparam int EVENTS      = 8;
    localparam int PORTS       = 8;
    localparam int EV_W        = (EVENTS > 1) ? $clog2(EVENTS) : 1;
    localparam int DAY_MINUTES = 24 * 60;

    typedef logic [PORTS-1:0] t_ports;
    typedef logic [EV_W-1:0]  t_ev_idx;
    typedef logic [10:0]      t_daytime;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_SET   = 2'd2,
        CMD_FLIP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       active;
        logic [3:0] port;
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [4:0] end_hour;
        logic [5:0] end_minute;
    } t_event;

    // Minutes since midnight, wrapped once into the day.
    function automatic t_daytime day_time(input logic [4:0] hour, input logic [5:0] minute);
        logic [11:0] sum;
        sum = {1'b0, hour, 6'b0} - {5'b0, hour, 2'b0} + {6'b0, minute};
        if (sum >= 12'(DAY_MINUTES)) begin
            sum = sum - 12'(DAY_MINUTES);
        end
        return sum[10:0];
    endfunction

endpackage

`default_nettype wire

// File: src/tos_event_table.sv
`default_nettype none

module tos_event_table
    import tos_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_wr_en,
    input  wire t_ev_idx i_wr_idx,
    input  wire t_event  i_wr_event,
    input  wire t_ev_idx i_rd_idx,
    output t_event       o_rd_event
);

    t_event r_tab [EVENTS];
    logic   r_act [EVENTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < EVENTS; k++) begin
                r_act[k] <= 1'b0;
            end
        end else if (i_wr_en) begin
            r_act[i_wr_idx] <= i_wr_event.active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tab[i_wr_idx] <= i_wr_event;
        end
    end

    // The read address is the next scan index, so the entry is ready when the scan reaches it.
    always_ff @(posedge i_clk) begin
        o_rd_event <= {r_act[i_rd_idx], r_tab[i_rd_idx][25:0]};
    end

endmodule

`default_nettype wire

// File: src/tos_window.sv
`default_nettype none

module tos_window
    import tos_pkg::*;
(
    input  wire t_event   i_event,
    input  wire t_daytime i_now,
    output logic          o_hit
);

    t_daytime start_t;
    t_daytime end_t;
    t_daytime span;
    t_daytime pos;

    always_comb begin
        start_t = day_time(i_event.start_hour, i_event.start_minute);
        end_t   = day_time(i_event.end_hour, i_event.end_minute);
        if (end_t >= start_t) begin
            span = end_t - start_t;
        end else begin
            span = end_t - start_t + 11'(DAY_MINUTES);
        end
        if (i_now >= start_t) begin
            pos = i_now - start_t;
        end else begin
            pos = i_now - start_t + 11'(DAY_MINUTES);
        end
        o_hit = (pos < span);
    end

endmodule

`default_nettype wire

// File: src/timed_output_scheduler.sv
`default_nettype none

// Channel   Direction  Handshake                  Word
// input     in         i_in_valid / o_in_stall    i_command ... i_pin_value
// result    out        o_out_valid / i_out_stall  o_port_levels, o_changed_mask
//
// A tick takes the word, then passes each table entry in turn through the shared window unit,
// then finishes. Other commands go from taking the word straight to the finish state.
// Reset clears the port levels and every active flag.
// A finished word waits in the output register while the next word is taken; the
// sequencer holds in its finish state until that register is free.

module timed_output_scheduler
    import tos_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_command,
    input  wire logic [4:0] i_now_hour,
    input  wire logic [5:0] i_now_minute,
    input  wire logic [2:0] i_event_index,
    input  wire logic       i_event_active,
    input  wire logic [3:0] i_port,
    input  wire logic [4:0] i_start_hour,
    input  wire logic [5:0] i_start_minute,
    input  wire logic [4:0] i_end_hour,
    input  wire logic [5:0] i_end_minute,
    input  wire logic       i_pin_value,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_port_levels,
    output logic [7:0]      o_changed_mask
);

    t_state   r_state, n_state;
    t_cmd     r_cmd, n_cmd;
    logic [3:0] r_port, n_port;
    logic     r_pin, n_pin;
    t_daytime r_now, n_now;
    t_ev_idx  r_idx, n_idx;
    t_ports   r_driven, n_driven;
    t_ports   r_high, n_high;
    t_ports   r_levels, n_levels;
    logic     r_out_valid, n_out_valid;
    logic [7:0] r_out_levels, n_out_levels;
    logic [7:0] r_out_changed, n_out_changed;

    logic     in_acc;
    logic     can_load;
    logic     wr_en;
    t_event   wr_event;
    t_event   rd_event;
    logic     hit;
    t_ports   ev_bit;
    t_ports   cmd_bit;
    t_ports   lvl_next;

    assign o_in_stall     = (r_state != S_IDLE);
    assign in_acc         = i_in_valid && !o_in_stall;
    assign can_load       = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_port_levels  = r_out_levels;
    assign o_changed_mask = r_out_changed;

    assign wr_en = in_acc && (i_command == CMD_WRITE) && (int'(i_event_index) < EVENTS);

    always_comb begin
        wr_event.active       = i_event_active;
        wr_event.port         = i_port;
        wr_event.start_hour   = i_start_hour;
        wr_event.start_minute = i_start_minute;
        wr_event.end_hour     = i_end_hour;
        wr_event.end_minute   = i_end_minute;
    end

    tos_event_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_idx   (t_ev_idx'(i_event_index)),
        .i_wr_event (wr_event),
        .i_rd_idx   (n_idx),
        .o_rd_event (rd_event)
    );

    tos_window u_window (
        .i_event (rd_event),
        .i_now   (r_now),
        .o_hit   (hit)
    );

    assign ev_bit  = t_ports'(1) << rd_event.port;
    assign cmd_bit = t_ports'(1) << r_port;

    always_comb begin
        lvl_next = r_levels;
        case (r_cmd)
            CMD_TICK: begin
                lvl_next = (r_levels & ~r_driven) | r_high;
            end
            CMD_SET: begin
                if (int'(r_port) < PORTS) begin
                    lvl_next = r_pin ? (r_levels | cmd_bit) : (r_levels & ~cmd_bit);
                end
            end
            CMD_FLIP: begin
                if (int'(r_port) < PORTS) begin
                    lvl_next = r_levels ^ cmd_bit;
                end
            end
            default: begin
                lvl_next = r_levels;
            end
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_port        = r_port;
        n_pin         = r_pin;
        n_now         = r_now;
        n_idx         = r_idx;
        n_driven      = r_driven;
        n_high        = r_high;
        n_levels      = r_levels;
        n_out_levels  = r_out_levels;
        n_out_changed = r_out_changed;
        n_out_valid   = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd    = t_cmd'(i_command);
                    n_port   = i_port;
                    n_pin    = i_pin_value;
                    n_now    = day_time(i_now_hour, i_now_minute);
                    n_idx    = '0;
                    n_driven = '0;
                    n_high   = '0;
                    n_state  = (i_command == CMD_TICK) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (rd_event.active && (int'(rd_event.port) < PORTS)) begin
                    n_driven = r_driven | ev_bit;
                    if (hit) begin
                        n_high = r_high | ev_bit;
                    end
                end
                if (r_idx == t_ev_idx'(EVENTS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + t_ev_idx'(1);
                end
            end
            S_DONE: begin
                if (can_load) begin
                    n_levels      = lvl_next;
                    n_out_levels  = 8'(lvl_next);
                    n_out_changed = 8'(lvl_next ^ r_levels);
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_levels    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_levels    <= n_levels;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_port        <= n_port;
        r_pin         <= n_pin;
        r_now         <= n_now;
        r_driven      <= n_driven;
        r_high        <= n_high;
        r_out_levels  <= n_out_levels;
        r_out_changed <= n_out_changed;
    end

    a_nontick_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_command != CMD_TICK) |=> (r_state == S_DONE))
        else $error("Non-tick word did not go straight to finish.");

    a_tick_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_command == CMD_TICK) |=> (r_state == S_SCAN && r_idx == '0))
        else $error("Tick scan did not start at the first entry.");

    a_write_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && can_load && r_cmd == CMD_WRITE)
            |=> (o_out_valid && o_changed_mask == 8'd0))
        else $error("Write word reported a level change.");

    a_levels_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_port_levels == 8'(r_levels)))
        else $error("Output levels differ from the level register.");

endmodule

`default_nettype wire
